### hdl/irpd_pkg.sv
// Package for the IR pulse-distance code matcher: payload structs, symbol codes,
// sizing constants and the button code table.
// No dependencies; used by irpd_cell and ir_pulse_distance_code_matcher_unit.
`timescale 1ns / 1ps
`default_nettype none

package irpd_pkg;

    localparam int SYMBOLS_PER_CODE = 34;
    localparam int TABLE_ENTRIES    = 13;
    localparam int TICK_DIVISOR     = 80;

    localparam int LIMIT_W     = 16;
    localparam int SHORT_RESET = 750;
    localparam int LONG_RESET  = 1450;

    localparam int ROM_ROWS  = 13;
    localparam int ROM_WIDTH = 34;
    localparam int ROW_W     = $clog2(ROM_ROWS);

    // register indexes on the config port (byte address = 4 * index)
    localparam logic REG_SHORT_LIMIT = 1'b0;
    localparam logic REG_LONG_LIMIT  = 1'b1;

    typedef enum logic [1:0] {
        SYM_A = 2'd0,
        SYM_B = 2'd1,
        SYM_X = 2'd2
    } t_sym;

    typedef struct packed {
        logic        kind;
        logic [31:0] edge_time;
    } t_in;

    typedef struct packed {
        logic       matched;
        logic [3:0] button;
    } t_out;

    // input kind codes
    localparam logic KIND_EDGE  = 1'b0;
    localparam logic KIND_REARM = 1'b1;

    // button codes, first character is symbol position 0
    localparam logic [8*ROM_WIDTH-1:0] ROM_TXT [ROM_ROWS] = '{
        "XXAABAAAAABBABBBBBAAAABAAABBBBABBB",
        "XXAABAAAAABBABBBBBBAAABAAAABBBABBB",
        "XXAABAAAAABBABBBBBABAABAAABABBABBB",
        "XXAABAAAAABBABBBBBBBAABAAAAABBABBB",
        "XXAABAAAAABBABBBBBAABABAAABBABABBB",
        "XXAABAAAAABBABBBBBBABABAAAABABABBB",
        "XXAABAAAAABBABBBBBABBABAAABAABABBB",
        "XXAABAAAAABBABBBBBBBBABAAAAAABABBB",
        "XXAABAAAAABBABBBBBAAABBAAABBBAABBB",
        "XXAABAAAAABBABBBBBBAABBAAAABBAABBB",
        "XXAABAAAAABBABBBBBAABAAABABBABBBAB",
        "XXAABAAAAABBABBBBBAAABABAABBBABABB",
        "XXAABAAAAABBABBBBBBAAAAABAABBBBBAB"
    };

    // table symbol at (row, pos); positions past the table width read as X
    function automatic t_sym rom_symbol(input int row, input int pos);
        logic [7:0] c;
        t_sym       s;
        s = SYM_X;
        if (row < ROM_ROWS && pos < ROM_WIDTH) begin
            c = ROM_TXT[row[ROW_W-1:0]][8*(ROM_WIDTH-1-pos) +: 8];
            if (c == "A") begin
                s = SYM_A;
            end else if (c == "B") begin
                s = SYM_B;
            end
        end
        return s;
    endfunction

endpackage

`default_nettype wire

### hdl/irpd_cell.sv
// One cell of the symbol shift line: holds the symbol at position POS and
// flags, per table row, whether it equals that row's symbol there. Uses irpd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module irpd_cell #(
    parameter int POS           = 0,
    parameter int TABLE_ENTRIES = irpd_pkg::TABLE_ENTRIES
) (
    input  wire                      i_clk,
    input  wire                      i_shift,
    input  irpd_pkg::t_sym           i_sym,
    output irpd_pkg::t_sym           o_sym,
    output logic [TABLE_ENTRIES-1:0] o_eq
);

    irpd_pkg::t_sym r_sym;

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_sym <= i_sym;
        end
    end

    assign o_sym = r_sym;

    // rows past the end of the table never match
    always_comb begin
        for (int r = 0; r < TABLE_ENTRIES; r++) begin
            o_eq[r] = (r < irpd_pkg::ROM_ROWS) && (r_sym == irpd_pkg::rom_symbol(r, POS));
        end
    end

endmodule

`default_nettype wire

### hdl/ir_pulse_distance_code_matcher_unit.sv
// Top level of the IR pulse-distance code matcher: interval classifier,
// symbol shift line of irpd_cell, table match, output register, APB config.
// Depends on irpd_pkg and irpd_cell.
//
//  channel  | direction | handshake                    | payload
//  ---------+-----------+------------------------------+---------------------
//  in       | input     | i_in_valid / o_in_stall      | i_in_data  (t_in)
//  out      | output    | o_out_valid / i_out_stall    | o_out_data (t_out)
//  config   | input     | psel/penable/pwrite, pready  | paddr, pwdata, prdata
//
// One input transfer per cycle while o_in_stall is low. An edge is classified
// and shifted into the cell line in the cycle it is taken; the finished word is
// matched against the table and loaded into the output register once that is
// empty or being read. The input stalls only while a finished match waits for a
// stalled output. Synchronous active-low reset; no clearing pass, the line is
// fully written before each match.
`timescale 1ns / 1ps
`default_nettype none

module ir_pulse_distance_code_matcher_unit #(
    parameter int SYMBOLS_PER_CODE = irpd_pkg::SYMBOLS_PER_CODE,
    parameter int TABLE_ENTRIES    = irpd_pkg::TABLE_ENTRIES,
    parameter int TICK_DIVISOR     = irpd_pkg::TICK_DIVISOR
) (
    input  wire             i_clk,
    input  wire             i_rst_n,

    input  wire             i_in_valid,
    output logic            o_in_stall,
    input  irpd_pkg::t_in   i_in_data,

    output logic            o_out_valid,
    input  wire             i_out_stall,
    output irpd_pkg::t_out  o_out_data,

    input  wire             psel,
    input  wire             penable,
    input  wire             pwrite,
    input  wire [2:0]       paddr,
    input  wire [31:0]      pwdata,
    output logic [31:0]     prdata,
    output logic            pready
);

    localparam int LW    = irpd_pkg::LIMIT_W;
    localparam int THR_W = LW + $clog2(TICK_DIVISOR);
    localparam int CNT_W = $clog2(SYMBOLS_PER_CODE);
    localparam logic [THR_W-1:0] DIV_M1    = THR_W'(TICK_DIVISOR - 1);
    localparam logic [THR_W-1:0] SHORT_THR =
        THR_W'(irpd_pkg::SHORT_RESET * TICK_DIVISOR + TICK_DIVISOR - 1);
    localparam logic [THR_W-1:0] LONG_THR  =
        THR_W'(irpd_pkg::LONG_RESET * TICK_DIVISOR + TICK_DIVISOR - 1);
    localparam logic [CNT_W-1:0] LAST_POS  = CNT_W'(SYMBOLS_PER_CODE - 1);

    // ---------------- configuration ----------------
    logic [LW-1:0]    r_short_limit, r_long_limit;
    logic [THR_W-1:0] r_short_thr, r_long_thr;
    logic [THR_W-1:0] n_thr;
    logic             w_cfg_wr;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel & penable & pwrite & pready;

    // scaled <= limit  <=>  interval <= limit*divisor + divisor-1
    assign n_thr = THR_W'(pwdata[LW-1:0]) * THR_W'(TICK_DIVISOR) + DIV_M1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_short_limit <= LW'(irpd_pkg::SHORT_RESET);
            r_long_limit  <= LW'(irpd_pkg::LONG_RESET);
            r_short_thr   <= SHORT_THR;
            r_long_thr    <= LONG_THR;
        end else if (w_cfg_wr) begin
            if (paddr[2] == irpd_pkg::REG_SHORT_LIMIT) begin
                r_short_limit <= pwdata[LW-1:0];
                r_short_thr   <= n_thr;
            end else begin
                r_long_limit <= pwdata[LW-1:0];
                r_long_thr   <= n_thr;
            end
        end
    end

    always_comb begin
        if (paddr[2] == irpd_pkg::REG_SHORT_LIMIT) begin
            prdata = {{(32-LW){1'b0}}, r_short_limit};
        end else begin
            prdata = {{(32-LW){1'b0}}, r_long_limit};
        end
    end

    // ---------------- capture control ----------------
    logic [31:0]      r_prev;
    logic [CNT_W-1:0] r_count;
    logic             r_capturing;
    logic             r_pend;
    logic             r_out_valid;
    irpd_pkg::t_out   r_out_data;

    logic             w_accept, w_edge, w_last, w_load;
    logic [31:0]      w_interval;
    irpd_pkg::t_sym   w_sym;
    irpd_pkg::t_out   w_match;

    assign w_load     = r_pend & (~r_out_valid | ~i_out_stall);
    assign o_in_stall = r_pend & r_out_valid & i_out_stall;
    assign w_accept   = i_in_valid & ~o_in_stall;
    assign w_edge     = w_accept & (i_in_data.kind == irpd_pkg::KIND_EDGE) & r_capturing;
    assign w_last     = (r_count == LAST_POS);
    assign w_interval = i_in_data.edge_time - r_prev;   // wraps modulo 2^32

    always_comb begin
        if (w_interval <= 32'(r_short_thr)) begin
            w_sym = irpd_pkg::SYM_A;
        end else if (w_interval <= 32'(r_long_thr)) begin
            w_sym = irpd_pkg::SYM_B;
        end else begin
            w_sym = irpd_pkg::SYM_X;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev      <= '0;
            r_count     <= '0;
            r_capturing <= 1'b1;
            r_pend      <= 1'b0;
        end else begin
            if (w_edge) begin
                r_prev <= i_in_data.edge_time;
                if (w_last) begin
                    r_count     <= '0;
                    r_capturing <= 1'b0;
                    r_pend      <= 1'b1;
                end else begin
                    r_count <= r_count + 1'b1;
                end
            end else if (w_accept && i_in_data.kind == irpd_pkg::KIND_REARM) begin
                r_capturing <= 1'b1;
            end
            if (w_load) begin
                r_pend <= 1'b0;
            end
        end
    end

    // ---------------- symbol cell line ----------------
    // new symbol enters the top cell; after a full code cell k holds position k
    irpd_pkg::t_sym           w_cell_sym [SYMBOLS_PER_CODE+1];
    logic [TABLE_ENTRIES-1:0] w_eq       [SYMBOLS_PER_CODE];

    assign w_cell_sym[SYMBOLS_PER_CODE] = w_sym;

    for (genvar k = 0; k < SYMBOLS_PER_CODE; k++) begin : g_cell
        irpd_cell #(
            .POS           (k),
            .TABLE_ENTRIES (TABLE_ENTRIES)
        ) u_cell (
            .i_clk   (i_clk),
            .i_shift (w_edge),
            .i_sym   (w_cell_sym[k+1]),
            .o_sym   (w_cell_sym[k]),
            .o_eq    (w_eq[k])
        );
    end

    // ---------------- table match ----------------
    logic [TABLE_ENTRIES-1:0] w_hit;

    always_comb begin
        w_hit = '1;
        for (int k = 0; k < SYMBOLS_PER_CODE; k++) begin
            w_hit = w_hit & w_eq[k];
        end
        w_match = '0;
        // lowest matching row wins
        for (int r = TABLE_ENTRIES - 1; r >= 0; r--) begin
            if (w_hit[r]) begin
                w_match.matched = 1'b1;
                w_match.button  = 4'(r);
            end
        end
    end

    // ---------------- output register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_data <= w_match;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

`default_nettype wire

### verif/irpd_code_checker.sv
// Code matcher checker: watches the edge, result and APB channels, keeps its own
// copy of limits, symbol line and capture state, and compares every result transfer.
// Depends on irpd_pkg (payload types, symbol codes, button code table).
`timescale 1ns / 1ps

module irpd_code_checker (
    input  wire             i_clk,
    input  wire             i_rst_n,

    input  wire             i_in_valid,
    input  wire             i_in_stall,
    input  irpd_pkg::t_in   i_in_data,

    input  wire             i_out_valid,
    input  wire             i_out_stall,
    input  irpd_pkg::t_out  i_out_data,

    input  wire             i_psel,
    input  wire             i_penable,
    input  wire             i_pwrite,
    input  wire             i_pready,
    input  wire [2:0]       i_paddr,
    input  wire [31:0]      i_pwdata,

    output int              o_mismatches,
    output int              o_outstanding
);

    irpd_pkg::t_sym code_word [irpd_pkg::ROM_ROWS][irpd_pkg::SYMBOLS_PER_CODE];
    irpd_pkg::t_sym sym_line [irpd_pkg::SYMBOLS_PER_CODE];
    logic [31:0]    last_edge;
    int             sym_count;
    logic           armed;
    logic [15:0]    short_lim;
    logic [15:0]    long_lim;
    irpd_pkg::t_out expected_codes [$];
    int             fail_total = 0;
    int             waiting_count = 0;

    assign o_mismatches  = fail_total;
    assign o_outstanding = waiting_count;

    // table text -> symbols; positions past the text width count as X
    initial begin
        logic [7:0] c;
        for (int r = 0; r < irpd_pkg::ROM_ROWS; r++) begin
            for (int p = 0; p < irpd_pkg::SYMBOLS_PER_CODE; p++) begin
                code_word[r][p] = irpd_pkg::SYM_X;
                if (p < irpd_pkg::ROM_WIDTH) begin
                    c = irpd_pkg::ROM_TXT[r][8*(irpd_pkg::ROM_WIDTH-1-p) +: 8];
                    if (c == "A") begin
                        code_word[r][p] = irpd_pkg::SYM_A;
                    end else if (c == "B") begin
                        code_word[r][p] = irpd_pkg::SYM_B;
                    end
                end
            end
        end
    end

    task automatic report_mismatch(input string msg);
        fail_total++;
        $display("%0t ns  mismatch: %s", $time, msg);
    endtask

    // lowest table row equal to the full symbol line
    function automatic irpd_pkg::t_out match_word();
        irpd_pkg::t_out r;
        logic           hit;
        r = '0;
        for (int row = 0; row < irpd_pkg::TABLE_ENTRIES; row++) begin
            if (!r.matched && row < irpd_pkg::ROM_ROWS) begin
                hit = 1'b1;
                for (int p = 0; p < irpd_pkg::SYMBOLS_PER_CODE; p++) begin
                    if (sym_line[p] != code_word[row][p]) begin
                        hit = 1'b0;
                    end
                end
                if (hit) begin
                    r.matched = 1'b1;
                    r.button  = 4'(row);
                end
            end
        end
        return r;
    endfunction

    task automatic take_item(input irpd_pkg::t_in it);
        logic [31:0]    scaled;
        irpd_pkg::t_sym s;
        if (it.kind == irpd_pkg::KIND_REARM) begin
            armed = 1'b1;
        end else if (armed) begin
            // modulo-2^32 interval handles timer wrap
            scaled = (it.edge_time - last_edge) / irpd_pkg::TICK_DIVISOR;
            if (scaled <= short_lim) begin
                s = irpd_pkg::SYM_A;
            end else if (scaled <= long_lim) begin
                s = irpd_pkg::SYM_B;
            end else begin
                s = irpd_pkg::SYM_X;
            end
            last_edge = it.edge_time;
            if (sym_count >= irpd_pkg::SYMBOLS_PER_CODE) begin
                sym_count = 0;
            end
            sym_line[sym_count] = s;
            if (sym_count == irpd_pkg::SYMBOLS_PER_CODE - 1) begin
                sym_count = 0;
                armed     = 1'b0;
                expected_codes.push_back(match_word());
            end else begin
                sym_count++;
            end
        end
    endtask

    task automatic check_result(input irpd_pkg::t_out got);
        irpd_pkg::t_out want;
        if (expected_codes.size() == 0) begin
            report_mismatch($sformatf("result transfer with none expected (matched=%0b button=%0d)",
                                      got.matched, got.button));
        end else begin
            want = expected_codes.pop_front();
            if (got.matched !== want.matched) begin
                report_mismatch($sformatf("matched got %0b want %0b", got.matched, want.matched));
            end
            if (got.button !== want.button) begin
                report_mismatch($sformatf("button got %0d want %0d", got.button, want.button));
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            short_lim = 16'(irpd_pkg::SHORT_RESET);
            long_lim  = 16'(irpd_pkg::LONG_RESET);
            last_edge = '0;
            sym_count = 0;
            armed     = 1'b1;
            expected_codes.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                if (i_paddr[2] == irpd_pkg::REG_SHORT_LIMIT) begin
                    short_lim = i_pwdata[15:0];
                end else begin
                    long_lim = i_pwdata[15:0];
                end
            end
            if (i_in_valid && !i_in_stall) begin
                take_item(i_in_data);
            end
            if (i_out_valid && !i_out_stall) begin
                check_result(i_out_data);
            end
        end
        waiting_count = expected_codes.size();
    end

endmodule

### verif/testbench.sv
// Top of the code matcher testbench: clock, reset, edge/rearm stimulus, APB limit
// writes, output stalls and the verdict. Depends on irpd_pkg, the matcher unit and
// irpd_code_checker, which does all prediction and comparison.
`timescale 1ns / 1ps

module testbench;

    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASES      = 6;
    localparam int PHASE_ITEMS = 1550 / PHASES;
    localparam int TICKS       = irpd_pkg::TICK_DIVISOR;
    localparam int SHORT_RST   = irpd_pkg::SHORT_RESET;
    localparam int LONG_RST    = irpd_pkg::LONG_RESET;
    localparam int WORD_LEN    = irpd_pkg::SYMBOLS_PER_CODE;

    logic           clk = 1'b0;
    logic           rst_n;
    logic           in_valid;
    logic           in_stall;
    irpd_pkg::t_in  in_data;
    logic           out_valid;
    logic           out_stall = 1'b0;
    irpd_pkg::t_out out_data;
    logic           psel;
    logic           penable;
    logic           pwrite;
    logic [2:0]     paddr;
    logic [31:0]    pwdata;
    logic [31:0]    prdata;
    logic           pready;

    int          mismatches;
    int          outstanding;
    int          cycles = 0;
    int          tx_idle_pct = 0;
    int          rx_idle_pct = 0;

    // stimulus-side view of the block, used only to shape sequences
    logic [31:0] prev_sh = '0;
    logic        cap_sh = 1'b1;
    int          cnt_sh = 0;
    int          counted = 0;
    logic [15:0] short_lim = 16'(irpd_pkg::SHORT_RESET);
    logic [15:0] long_lim = 16'(irpd_pkg::LONG_RESET);

    ir_pulse_distance_code_matcher_unit dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    irpd_code_checker checker_inst (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .i_in_stall    (in_stall),
        .i_in_data     (in_data),
        .i_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .i_out_data    (out_data),
        .i_psel        (psel),
        .i_penable     (penable),
        .i_pwrite      (pwrite),
        .i_pready      (pready),
        .i_paddr       (paddr),
        .i_pwdata      (pwdata),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("ir_pulse_distance_code_matcher_unit verification failed");
            $finish;
        end
    end

    always @(negedge clk) begin
        out_stall <= ($urandom_range(99) < rx_idle_pct);
    end

    // one transfer on the edge channel; returns at the falling edge after it
    task automatic push_item(input logic kind, input logic [31:0] stamp);
        irpd_pkg::t_in it;
        while ($urandom_range(99) < tx_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        it.kind      = kind;
        it.edge_time = stamp;
        in_valid <= 1'b1;
        in_data  <= it;
        @(posedge clk);
        while (in_stall) begin
            @(posedge clk);
        end
        @(negedge clk);
        counted++;
        if (kind == irpd_pkg::KIND_REARM) begin
            cap_sh = 1'b1;
        end else if (cap_sh) begin
            prev_sh = stamp;
            if (cnt_sh == WORD_LEN - 1) begin
                cnt_sh = 0;
                cap_sh = 1'b0;
            end else begin
                cnt_sh++;
            end
        end
    endtask

    // interval whose scaled value falls in the class of s (class A if s cannot be made); boundaries favored
    function automatic logic [31:0] pick_gap(input irpd_pkg::t_sym s);
        longint lo;
        longint hi;
        longint scaled;
        lo = 0;
        hi = short_lim;
        if (s == irpd_pkg::SYM_B) begin
            lo = longint'(short_lim) + 1;
            hi = long_lim;
        end else if (s == irpd_pkg::SYM_X) begin
            lo = ((short_lim > long_lim) ? longint'(short_lim) : longint'(long_lim)) + 1;
            hi = ($urandom_range(7) == 0) ? 53687090 : lo + 70000;
        end
        if (hi < lo) begin
            // class cannot be made with these limits
            lo = 0;
            hi = short_lim;
        end
        case ($urandom_range(3))
            0: scaled = lo;
            1: scaled = hi;
            default: scaled = lo + longint'($urandom_range(32'(hi - lo)));
        endcase
        return 32'(scaled * TICKS + $urandom_range(TICKS - 1));
    endfunction

    task automatic push_symbol(input irpd_pkg::t_sym s);
        push_item(irpd_pkg::KIND_EDGE, prev_sh + pick_gap(s));
    endtask

    // a button word from the table, sometimes with one wrong symbol or cut short
    task automatic push_code();
        int             row;
        int             flip;
        int             cut;
        irpd_pkg::t_sym s;
        logic [7:0]     c;
        while (cap_sh && cnt_sh != 0) begin
            push_item(irpd_pkg::KIND_EDGE, $urandom);
        end
        if (!cap_sh) begin
            push_item(irpd_pkg::KIND_REARM, $urandom);
        end
        row  = $urandom_range(irpd_pkg::ROM_ROWS - 1);
        flip = ($urandom_range(6) == 0) ? $urandom_range(WORD_LEN - 1) : -1;
        cut  = ($urandom_range(9) == 0) ? $urandom_range(WORD_LEN - 1, 1) : WORD_LEN;
        for (int p = 0; p < cut; p++) begin
            if ($urandom_range(19) == 0) begin
                push_item(irpd_pkg::KIND_REARM, $urandom);
            end
            c = irpd_pkg::ROM_TXT[row][8*(irpd_pkg::ROM_WIDTH-1-p) +: 8];
            s = (c == "A") ? irpd_pkg::SYM_A : (c == "B") ? irpd_pkg::SYM_B : irpd_pkg::SYM_X;
            if (p == flip) begin
                s = irpd_pkg::t_sym'((int'(s) + 1 + $urandom_range(1)) % 3);
            end
            push_symbol(s);
        end
        // edges after a finished word must be dropped
        if (!cap_sh) begin
            repeat ($urandom_range(2)) push_item(irpd_pkg::KIND_EDGE, $urandom);
        end
    endtask

    task automatic push_noise();
        repeat ($urandom_range(6, 1)) begin
            push_item(($urandom_range(3) == 0) ? irpd_pkg::KIND_REARM : irpd_pkg::KIND_EDGE,
                      $urandom_range(1) ? $urandom : prev_sh + $urandom_range(200000));
        end
    endtask

    task automatic write_limit(input logic idx, input logic [15:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {16'($urandom), value};
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) begin
            @(posedge clk);
        end
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
        if (idx == irpd_pkg::REG_SHORT_LIMIT) begin
            short_lim = value;
        end else begin
            long_lim = value;
        end
    endtask

    // wait until all expected results are in, then let the match stage settle
    task automatic drain();
        in_valid <= 1'b0;
        @(negedge clk);
        while (outstanding != 0) begin
            @(negedge clk);
        end
        repeat (4) @(negedge clk);
    endtask

    initial begin
        int target;
        int tries;
        int s;
        rst_n    = 1'b0;
        in_valid = 1'b0;
        in_data  = '0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph / 2)
                0: begin tx_idle_pct = 19; rx_idle_pct = 51; end
                1: begin tx_idle_pct = 51; rx_idle_pct = 19; end
                default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
            endcase
            if (ph > 0) begin
                drain();
            end
            case (ph)
                1: begin
                    write_limit(irpd_pkg::REG_SHORT_LIMIT, 16'd0);
                    write_limit(irpd_pkg::REG_LONG_LIMIT, 16'd0);
                end
                2: begin
                    write_limit(irpd_pkg::REG_SHORT_LIMIT, 16'hFFFF);
                    write_limit(irpd_pkg::REG_LONG_LIMIT, 16'hFFFF);
                end
                3: begin
                    // limits out of order: no B symbols
                    write_limit(irpd_pkg::REG_SHORT_LIMIT, 16'd1450);
                    write_limit(irpd_pkg::REG_LONG_LIMIT, 16'd750);
                end
                4: begin
                    s = $urandom_range(3000, 1);
                    write_limit(irpd_pkg::REG_SHORT_LIMIT, 16'(s));
                    write_limit(irpd_pkg::REG_LONG_LIMIT, 16'(s + $urandom_range(3000, 1)));
                end
                5: begin
                    write_limit(irpd_pkg::REG_SHORT_LIMIT, 16'd0);
                    write_limit(irpd_pkg::REG_LONG_LIMIT, 16'hFFFF);
                end
                default: ;
            endcase

            if (ph == 0) begin
                push_item(irpd_pkg::KIND_EDGE, 32'h0000_0000);
                push_item(irpd_pkg::KIND_EDGE, 32'hFFFF_FFFF);
                push_item(irpd_pkg::KIND_EDGE, 32'h0000_004F);      // timer wrap
                push_item(irpd_pkg::KIND_REARM, 32'hFFFF_FFFF);     // rearm while capturing
                push_item(irpd_pkg::KIND_EDGE, prev_sh + 32'(SHORT_RST * TICKS + TICKS - 1));
                push_item(irpd_pkg::KIND_EDGE, prev_sh + 32'((SHORT_RST + 1) * TICKS));
                push_item(irpd_pkg::KIND_EDGE, prev_sh + 32'(LONG_RST * TICKS + TICKS - 1));
                push_item(irpd_pkg::KIND_EDGE, prev_sh + 32'((LONG_RST + 1) * TICKS));
                push_item(irpd_pkg::KIND_EDGE, 32'h8000_0000);
                push_item(irpd_pkg::KIND_EDGE, 32'h7FFF_FFFF);      // largest interval
            end

            target = counted + PHASE_ITEMS;
            while (counted < target) begin
                if ($urandom_range(99) < 70) begin
                    push_code();
                end else begin
                    push_noise();
                end
            end
        end

        in_valid <= 1'b0;
        tries = 0;
        while (outstanding != 0 && tries < 5000) begin
            @(negedge clk);
            tries++;
        end
        repeat (10) @(negedge clk);
        if (mismatches == 0 && outstanding == 0) begin
            $display("ir_pulse_distance_code_matcher_unit verification clean");
        end else begin
            $display("ir_pulse_distance_code_matcher_unit verification failed");
        end
        $finish;
    end

endmodule

### ir_pulse_distance_code_matcher_unit.f
hdl/irpd_pkg.sv
hdl/irpd_cell.sv
hdl/ir_pulse_distance_code_matcher_unit.sv
verif/irpd_code_checker.sv
verif/testbench.sv
